@@ src/lsrd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and widths for the scan response decoder.
package lsrd_pkg;

   // Scan capacity in points
   localparam int MAX_POINTS = 2048;

   localparam int ByteWidth        = 8;
   localparam int DistWidth        = 18;
   localparam int IndexWidth       = 11;
   localparam int DigitWidth       = 6;
   localparam int GroupWidth       = 12;
   localparam int LineLenWidth     = 7;
   localparam int LineNumWidth     = 2;
   localparam int StatusWidth      = 24;
   localparam int GroupCountWidth  = 2;
   localparam int PointCountWidth  = $clog2(MAX_POINTS + 1);
   localparam int CountExtWidth    = (PointCountWidth > IndexWidth) ? PointCountWidth
                                                                     : IndexWidth;

   localparam logic [ByteWidth-1:0]       LF_CHAR           = 8'h0A;
   localparam logic [ByteWidth-1:0]       DIGIT_BASE        = 8'h30;
   localparam logic [StatusWidth-1:0]     STATUS_OK_TEXT    = 24'h303050;  // "00P"
   localparam logic [StatusWidth-1:0]     STATUS_RETRY_TEXT = 24'h313051;  // "10Q"
   localparam logic [LineLenWidth-1:0]    LINE_LEN_MAX      = 7'd127;
   localparam logic [LineLenWidth-1:0]    STATUS_LEN        = 7'd3;
   localparam logic [IndexWidth-1:0]      INDEX_MAX         = 11'd2047;

   // Line roles
   localparam logic [LineNumWidth-1:0]    LINE_ECHO      = 2'd0;
   localparam logic [LineNumWidth-1:0]    LINE_STATUS    = 2'd1;
   localparam logic [LineNumWidth-1:0]    LINE_TIMESTAMP = 2'd2;
   localparam logic [LineNumWidth-1:0]    LINE_DATA      = 2'd3;

   localparam logic [GroupCountWidth-1:0] GROUP_LAST_DIGIT = 2'd2;

endpackage

@@ src/lsrd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for reply bytes and decoded points.
interface lsrd_req_if
   import lsrd_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsrd_rsp_if
   import lsrd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [DistWidth-1:0]  distance;
   logic [IndexWidth-1:0] point_index;
   logic                  last;
   logic                  status_ok;
   logic                  retry_request;
   logic                  length_error;

   modport source (output valid, output distance, output point_index, output last,
                   output status_ok, output retry_request, output length_error,
                   input ready);
   modport sink   (input valid, input distance, input point_index, input last,
                   input status_ok, input retry_request, input length_error,
                   output ready);
endinterface

@@ src/lidar_scan_response_decoder_top.sv @@
`timescale 1ns / 1ps
// Range-finder reply decoder: byte stream in, range points and end-of-reply beat out.
//
// Takes one reply byte per beat on req_ch and returns decoded range points on rsp_ch.
// Line 0 (echo) and line 2 (timestamp) are skipped, line 1 is kept as status, and
// every later line is data whose last character (checksum) is dropped unchecked.
// Data characters are joined across lines; each three give an 18-bit distance,
// sent with its point index. Points beyond MAX_POINTS are dropped and flagged.
// A blank line ends the reply: a last beat carries the point count (capped at
// 2047), status_ok for "00P", retry_request for "10Q" and length_error for a
// leftover partial group or overflow; the decoder then starts afresh.
// Throughput is one byte per clock. A byte is decoded in the cycle it is taken
// and any result sits in the output register from the next cycle; req_ch is ready
// whenever that register is empty or being drained on the same edge, so the
// only stall comes from back-pressure on rsp_ch.
module lidar_scan_response_decoder_top
   import lsrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lsrd_req_if.sink  req_ch,
   lsrd_rsp_if.source rsp_ch
);

   // Parse state
   logic [LineNumWidth-1:0]    line_num_ff,    line_num_in;
   logic [LineLenWidth-1:0]    line_len_ff,    line_len_in;
   logic [ByteWidth-1:0]       held_char_ff,   held_char_in;
   logic                       held_valid_ff,  held_valid_in;
   logic [StatusWidth-1:0]     status_ff,      status_in;
   logic [GroupCountWidth-1:0] group_cnt_ff,   group_cnt_in;
   logic [GroupWidth-1:0]      group_val_ff,   group_val_in;
   logic [PointCountWidth-1:0] point_cnt_ff,   point_cnt_in;
   logic                       overflowed_ff,  overflowed_in;

   // Output register
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [DistWidth-1:0]  rsp_dist_ff,   rsp_dist_in;
   logic [IndexWidth-1:0] rsp_index_ff,  rsp_index_in;
   logic                  rsp_last_ff,   rsp_last_in;
   logic                  rsp_ok_ff,     rsp_ok_in;
   logic                  rsp_retry_ff,  rsp_retry_in;
   logic                  rsp_lerr_ff,   rsp_lerr_in;

   logic                   accept;
   logic                   emit;
   logic [ByteWidth-1:0]   byte_val;
   logic [DigitWidth-1:0]  digit;
   logic [CountExtWidth-1:0] count_ext;
   logic [IndexWidth-1:0]  count_capped;

   // Output register free now or emptied at this edge
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign byte_val     = req_ch.rx_byte;

   // Digit of the held character, out-of-range values wrap to 6 bits
   assign digit = DigitWidth'(held_char_ff - DIGIT_BASE);

   assign count_ext    = CountExtWidth'(point_cnt_ff);
   assign count_capped = (count_ext > CountExtWidth'(INDEX_MAX)) ? INDEX_MAX
                                                                 : IndexWidth'(point_cnt_ff);

   always_comb begin
      line_num_in   = line_num_ff;
      line_len_in   = line_len_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      status_in     = status_ff;
      group_cnt_in  = group_cnt_ff;
      group_val_in  = group_val_ff;
      point_cnt_in  = point_cnt_ff;
      overflowed_in = overflowed_ff;

      emit          = 1'b0;
      rsp_dist_in   = rsp_dist_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_retry_in  = rsp_retry_ff;
      rsp_lerr_in   = rsp_lerr_ff;

      if (accept) begin
         if (byte_val == LF_CHAR) begin
            if (line_len_ff == '0) begin
               // Blank line: end-of-reply beat, then back to the reset state
               emit          = 1'b1;
               rsp_dist_in   = '0;
               rsp_index_in  = count_capped;
               rsp_last_in   = 1'b1;
               rsp_ok_in     = (status_ff == STATUS_OK_TEXT);
               rsp_retry_in  = (status_ff == STATUS_RETRY_TEXT);
               rsp_lerr_in   = (group_cnt_ff != '0) || overflowed_ff;
               line_num_in   = LINE_ECHO;
               line_len_in   = '0;
               held_char_in  = '0;
               held_valid_in = 1'b0;
               status_in     = '0;
               group_cnt_in  = '0;
               group_val_in  = '0;
               point_cnt_in  = '0;
               overflowed_in = 1'b0;
            end else begin
               if (line_num_ff == LINE_STATUS && line_len_ff != STATUS_LEN) begin
                  status_in = '0;
               end
               // Held char of a data line is its checksum
               if (line_num_ff == LINE_DATA) begin
                  held_valid_in = 1'b0;
               end else begin
                  line_num_in = line_num_ff + 1'b1;
               end
               line_len_in = '0;
            end
         end else begin
            if (line_len_ff != LINE_LEN_MAX) begin
               line_len_in = line_len_ff + 1'b1;
            end
            case (line_num_ff)
               LINE_STATUS: begin
                  status_in = {status_ff[StatusWidth-ByteWidth-1:0], byte_val};
               end
               LINE_DATA: begin
                  if (held_valid_ff) begin
                     if (group_cnt_ff != GROUP_LAST_DIGIT) begin
                        group_val_in = {group_val_ff[GroupWidth-DigitWidth-1:0], digit};
                        group_cnt_in = group_cnt_ff + 1'b1;
                     end else begin
                        group_cnt_in = '0;
                        group_val_in = '0;
                        if (point_cnt_ff < PointCountWidth'(MAX_POINTS)) begin
                           emit         = 1'b1;
                           rsp_dist_in  = {group_val_ff, digit};
                           rsp_index_in = IndexWidth'(point_cnt_ff);
                           rsp_last_in  = 1'b0;
                           rsp_ok_in    = 1'b0;
                           rsp_retry_in = 1'b0;
                           rsp_lerr_in  = 1'b0;
                           point_cnt_in = point_cnt_ff + 1'b1;
                        end else begin
                           overflowed_in = 1'b1;
                        end
                     end
                  end
                  held_char_in  = byte_val;
                  held_valid_in = 1'b1;
               end
               default: begin
                  // Echo and timestamp lines carry nothing
               end
            endcase
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_num_ff   <= LINE_ECHO;
         line_len_ff   <= '0;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         status_ff     <= '0;
         group_cnt_ff  <= '0;
         group_val_ff  <= '0;
         point_cnt_ff  <= '0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         line_num_ff   <= line_num_in;
         line_len_ff   <= line_len_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         status_ff     <= status_in;
         group_cnt_ff  <= group_cnt_in;
         group_val_ff  <= group_val_in;
         point_cnt_ff  <= point_cnt_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // Payload, no reset needed
      rsp_dist_ff  <= rsp_dist_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_retry_ff <= rsp_retry_in;
      rsp_lerr_ff  <= rsp_lerr_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.distance      = rsp_dist_ff;
   assign rsp_ch.point_index   = rsp_index_ff;
   assign rsp_ch.last          = rsp_last_ff;
   assign rsp_ch.status_ok     = rsp_ok_ff;
   assign rsp_ch.retry_request = rsp_retry_ff;
   assign rsp_ch.length_error  = rsp_lerr_ff;

endmodule

@@ tb/sv/tb_lidar_scan_response_decoder_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the scan reply decoder: reply streams in, points checked on the fly.
module tb_lidar_scan_response_decoder_top;
   import lsrd_pkg::*;

   // ------------------------------------------------------------------
   // Bench constants
   // ------------------------------------------------------------------
   localparam int IDLE_PCT        = 71;    // heavy idling, either side
   localparam int BOTH_PCT        = 18;    // both sides idle together
   localparam int PHASE_BYTES     = 165;   // random reply bytes per idle phase
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int TAIL_CYCLES     = 8;     // registered output, plenty of margin
   localparam int MAX_REPORTS     = 40;    // keep the log short on a bad run
   localparam int LONG_POINTS     = 50;    // points in the over-long-line reply
   localparam int LONG_LINE       = 131;   // wraps to 3 if the line count ever wraps

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_type;

   // One decoded beat, as it appears on rsp_ch
   typedef struct packed {
      logic [DistWidth-1:0]  distance;
      logic [IndexWidth-1:0] point_index;
      logic                  last;
      logic                  status_ok;
      logic                  retry_request;
      logic                  length_error;
   } point_beat_type;

   // Directed stimulus row: the byte, and a hand-typed result where it is obvious
   typedef struct packed {
      logic [ByteWidth-1:0] rx;
      logic                 typed;
      point_beat_type       beat;
   } directed_row_type;

   localparam point_beat_type NO_BEAT = '0;
   localparam int DIRECTED_LEN = 23;

   // Three replies: a bare blank line straight after reset, a short well-formed
   // reply with status 00P and both distance extremes plus a leftover partial
   // group, and a reply cut short by a blank line inside the status line.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // blank line at once: empty reply, nothing recorded
      '{8'h0A, 1'b1, '{18'h00000, 11'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
      // echo "E"
      '{8'h45, 1'b0, NO_BEAT},
      '{8'h0A, 1'b0, NO_BEAT},
      // status "00P"
      '{8'h30, 1'b0, NO_BEAT},
      '{8'h30, 1'b0, NO_BEAT},
      '{8'h50, 1'b0, NO_BEAT},
      '{8'h0A, 1'b0, NO_BEAT},
      // timestamp "T"
      '{8'h54, 1'b0, NO_BEAT},
      '{8'h0A, 1'b0, NO_BEAT},
      // data "000" "ooo" 0xFF 0x00, checksum "Z"; each char lands one byte late
      '{8'h30, 1'b0, NO_BEAT},
      '{8'h30, 1'b0, NO_BEAT},
      '{8'h30, 1'b0, NO_BEAT},
      '{8'h6F, 1'b1, '{18'h00000, 11'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{8'h6F, 1'b0, NO_BEAT},
      '{8'h6F, 1'b0, NO_BEAT},
      '{8'hFF, 1'b1, '{18'h3FFFF, 11'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 1'b0, NO_BEAT},
      '{8'h5A, 1'b0, NO_BEAT},
      '{8'h0A, 1'b0, NO_BEAT},
      // blank line: two points, 00P, two digits left over
      '{8'h0A, 1'b1, '{18'h00000, 11'd2, 1'b1, 1'b1, 1'b0, 1'b1}},
      // echo "E" then blank line while the status line is still pending
      '{8'h45, 1'b0, NO_BEAT},
      '{8'h0A, 1'b0, NO_BEAT},
      '{8'h0A, 1'b1, '{18'h00000, 11'd0, 1'b1, 1'b0, 1'b0, 1'b0}}
   };

   // ------------------------------------------------------------------
   // Clock, reset, channels, block
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lsrd_req_if req_ch ();
   lsrd_rsp_if rsp_ch ();

   lidar_scan_response_decoder_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // ------------------------------------------------------------------
   // Decoder model state (bench copy)
   // ------------------------------------------------------------------
   logic [LineNumWidth-1:0]    line_no;
   logic [LineLenWidth-1:0]    line_len;
   logic [ByteWidth-1:0]       held_byte;
   logic                       held_live;
   logic [StatusWidth-1:0]     status_chars;
   logic [GroupCountWidth-1:0] group_digits;
   logic [GroupWidth-1:0]      group_acc;
   logic [PointCountWidth-1:0] points_out;
   logic                       points_lost;

   point_beat_type expected_points [$];   // beats still owed by the block

   // Stimulus and scoreboard bookkeeping
   logic [ByteWidth-1:0] reply_bytes [$];
   int  send_idle_pct    = 0;
   int  recv_stall_pct   = 0;
   bit  hold_off_pending = 1'b0;
   int  bytes_sent       = 0;
   int  beats_seen       = 0;
   int  points_checked   = 0;
   int  replies_checked  = 0;
   int  replies_ok       = 0;
   int  replies_retry    = 0;
   int  replies_bad_len  = 0;
   int  mismatch_count   = 0;

   function automatic void clear_decoder();
      line_no      = LINE_ECHO;
      line_len     = '0;
      held_byte    = '0;
      held_live    = 1'b0;
      status_chars = '0;
      group_digits = '0;
      group_acc    = '0;
      points_out   = '0;
      points_lost  = 1'b0;
   endfunction

   // Queue a beat at the back of the owed list
   function automatic void owe_beat(input point_beat_type beat);
      expected_points = {expected_points, beat};
   endfunction

   // Advance the model by one reply byte; queue any beat it produces.
   function automatic void decode_byte(input logic [ByteWidth-1:0] b);
      point_beat_type       beat;
      logic [ByteWidth-1:0] diff;
      beat = '0;
      if (b == LF_CHAR) begin
         if (line_len == '0) begin
            // blank line: end-of-reply beat, then start afresh
            beat.last          = 1'b1;
            beat.point_index   = (points_out > INDEX_MAX) ? INDEX_MAX
                                                          : points_out[IndexWidth-1:0];
            beat.status_ok     = (status_chars == STATUS_OK_TEXT);
            beat.retry_request = (status_chars == STATUS_RETRY_TEXT);
            beat.length_error  = (group_digits != '0) || points_lost;
            owe_beat(beat);
            clear_decoder();
         end else begin
            if (line_no == LINE_STATUS && line_len != STATUS_LEN)
               status_chars = '0;
            if (line_no == LINE_DATA)
               held_live = 1'b0;   // held char was the checksum
            if (line_no != LINE_DATA)
               line_no = line_no + 1'b1;
            line_len = '0;
         end
      end else begin
         if (line_len != LINE_LEN_MAX)
            line_len = line_len + 1'b1;
         if (line_no == LINE_STATUS) begin
            status_chars = {status_chars[StatusWidth-ByteWidth-1:0], b};
         end else if (line_no == LINE_DATA) begin
            if (held_live) begin
               diff = held_byte - DIGIT_BASE;
               if (group_digits != GROUP_LAST_DIGIT) begin
                  group_acc    = {group_acc[GroupWidth-DigitWidth-1:0], diff[DigitWidth-1:0]};
                  group_digits = group_digits + 1'b1;
               end else begin
                  if (points_out < MAX_POINTS) begin
                     beat.distance    = {group_acc, diff[DigitWidth-1:0]};
                     beat.point_index = points_out[IndexWidth-1:0];
                     owe_beat(beat);
                     points_out = points_out + 1'b1;
                  end else begin
                     points_lost = 1'b1;
                  end
                  group_digits = '0;
                  group_acc    = '0;
               end
            end
            held_byte = b;
            held_live = 1'b1;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting and beat comparison
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t: beat %0d: %s got 0x%0h, want 0x%0h", $time, beats_seen, what,
                  got, want);
      mismatch_count++;
   endtask

   task automatic check_beat(input point_beat_type got, input point_beat_type want);
      if (got.distance !== want.distance)
         report_mismatch("distance", 32'(got.distance), 32'(want.distance));
      if (got.point_index !== want.point_index)
         report_mismatch("point_index", 32'(got.point_index), 32'(want.point_index));
      if (got.last !== want.last)
         report_mismatch("last", 32'(got.last), 32'(want.last));
      if (got.status_ok !== want.status_ok)
         report_mismatch("status_ok", 32'(got.status_ok), 32'(want.status_ok));
      if (got.retry_request !== want.retry_request)
         report_mismatch("retry_request", 32'(got.retry_request), 32'(want.retry_request));
      if (got.length_error !== want.length_error)
         report_mismatch("length_error", 32'(got.length_error), 32'(want.length_error));
   endtask

   // Result monitor: values read just after the edge are the pre-edge values.
   point_beat_type got_beat;
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_beat = '{rsp_ch.distance, rsp_ch.point_index, rsp_ch.last, rsp_ch.status_ok,
                      rsp_ch.retry_request, rsp_ch.length_error};
         beats_seen++;
         if (expected_points.size() == 0) begin
            report_mismatch("beat with nothing owed, point_index",
                            32'(got_beat.point_index), 32'd0);
         end else begin
            check_beat(got_beat, expected_points.pop_front());
         end
         if (got_beat.last) begin
            replies_checked++;
            if (got_beat.status_ok)     replies_ok++;
            if (got_beat.retry_request) replies_retry++;
            if (got_beat.length_error)  replies_bad_len++;
         end else begin
            points_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            // block output register stays full; input must stall behind it
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: ends the run if no beat moves on either side for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat for %0d cycles, %0d beats still owed", $time, WATCHDOG_LIMIT,
               expected_points.size());
      $display("tb_lidar_scan_response_decoder_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   task automatic set_idle(input idle_phase_type phase);
      case (phase)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = IDLE_PCT;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = IDLE_PCT;
         end
         default: begin
            send_idle_pct  = BOTH_PCT;
            recv_stall_pct = BOTH_PCT;
         end
      endcase
   endtask

   // Offer one byte and wait for the edge that takes it. valid stays high
   // straight into the next byte unless an idle gap is drawn.
   task automatic push_byte(input logic [ByteWidth-1:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stop offering until every owed beat has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic send_reply();
      foreach (reply_bytes[i]) begin
         push_byte(reply_bytes[i]);
         decode_byte(reply_bytes[i]);
      end
   endtask

   // Add one byte at the end of the reply being built
   function automatic void append_byte(input logic [ByteWidth-1:0] b);
      reply_bytes = {reply_bytes, b};
   endfunction

   function automatic logic [ByteWidth-1:0] any_but_lf();
      logic [ByteWidth-1:0] c;
      do
         c = ByteWidth'($urandom_range(255));
      while (c == LF_CHAR);
      return c;
   endfunction

   // Mostly in the digit range; now and then any byte, to exercise the wrap.
   function automatic logic [ByteWidth-1:0] data_char();
      if ($urandom_range(9) == 0)
         return any_but_lf();
      return ByteWidth'($urandom_range(8'h6F, 8'h30));
   endfunction

   function automatic void add_chars(input int n, input bit printable);
      repeat (n)
         append_byte(printable ? ByteWidth'($urandom_range(8'h7E, 8'h20))
                               : any_but_lf());
   endfunction

   // Build one reply into reply_bytes. forced_points < 0 picks a random shape:
   // mostly well-formed, some cut short by an early blank line, some noise.
   // long_lines stretches echo and status past the line-length ceiling.
   task automatic build_reply(input int forced_points, input int min_chunk,
                              input int max_chunk, input bit long_lines);
      int shape;
      int early_blank;
      int status_kind;
      int points;
      int remaining;
      int chunk;
      reply_bytes.delete();
      shape       = (forced_points < 0) ? $urandom_range(99) : 99;
      early_blank = -1;
      if (shape < 10) begin
         // noise: raw bytes with stray line feeds, then two line feeds to resync
         repeat ($urandom_range(20, 1))
            append_byte(($urandom_range(99) < 15) ? LF_CHAR
                                                  : ByteWidth'($urandom_range(255)));
         append_byte(LF_CHAR);
         append_byte(LF_CHAR);
         return;
      end
      if (shape < 20)
         early_blank = $urandom_range(2);

      // echo line
      if (early_blank == 0) begin
         append_byte(LF_CHAR);
         return;
      end
      add_chars(long_lines ? LONG_LINE : $urandom_range(8, 1), 1'b1);
      append_byte(LF_CHAR);

      // status line: 00P, 10Q, other three chars, or the wrong length
      if (early_blank == 1) begin
         append_byte(LF_CHAR);
         return;
      end
      status_kind = $urandom_range(99);
      if (long_lines) begin
         add_chars(LONG_LINE - 3, 1'b0);
         status_kind = 0;
      end
      if (status_kind < 40) begin
         append_byte(8'h30);
         append_byte(8'h30);
         append_byte(8'h50);
      end else if (status_kind < 65) begin
         append_byte(8'h31);
         append_byte(8'h30);
         append_byte(8'h51);
      end else if (status_kind < 80) begin
         add_chars(3, 1'b0);
      end else begin
         add_chars(($urandom_range(1)) ? $urandom_range(2, 1) : $urandom_range(6, 4), 1'b0);
      end
      append_byte(LF_CHAR);

      // timestamp line
      if (early_blank == 2) begin
         append_byte(LF_CHAR);
         return;
      end
      add_chars($urandom_range(6, 1), 1'b0);
      append_byte(LF_CHAR);

      // data lines, payload split at random, checksum char on each
      points    = (forced_points < 0) ? $urandom_range(30) : forced_points;
      remaining = 3 * points;
      if (forced_points < 0 && $urandom_range(7) == 0)
         remaining += $urandom_range(2, 1);   // leftover partial group
      if (remaining == 0 && $urandom_range(1))
         remaining = -1;                      // checksum-only line
      while (remaining != 0) begin
         chunk = (remaining < 0) ? 0 : $urandom_range(max_chunk, min_chunk);
         if (chunk > remaining && remaining > 0)
            chunk = remaining;
         repeat (chunk) append_byte(data_char());
         append_byte(data_char());
         append_byte(LF_CHAR);
         remaining = (remaining < 0) ? 0 : remaining - chunk;
      end
      append_byte(LF_CHAR);
   endtask

   task automatic random_phase(input idle_phase_type phase);
      int start;
      set_idle(phase);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         build_reply(-1, 1, 40, 1'b0);
         send_reply();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      clear_decoder();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table; typed rows replace the model's beat with the hand value
      set_idle(IDLE_NONE);
      foreach (DIRECTED_ROWS[i]) begin
         int owed;
         owed = expected_points.size();
         push_byte(DIRECTED_ROWS[i].rx);
         decode_byte(DIRECTED_ROWS[i].rx);
         if (DIRECTED_ROWS[i].typed) begin
            if (expected_points.size() > owed)
               expected_points.delete(expected_points.size() - 1);
            owe_beat(DIRECTED_ROWS[i].beat);
         end
      end

      // receiver stops dead while a point-heavy reply keeps coming
      hold_off_pending = 1'b1;
      build_reply(60, 1, 40, 1'b0);
      send_reply();

      // sender waits for every owed beat before the over-long-line reply
      wait_drained();

      // over-long lines everywhere, status line wrapping test
      build_reply(LONG_POINTS, LONG_LINE - 3, LONG_LINE + 9, 1'b1);
      send_reply();

      random_phase(IDLE_NONE);
      random_phase(IDLE_SENDER);
      wait_drained();
      random_phase(IDLE_RECEIVER);
      random_phase(IDLE_BOTH);

      // let the last beats out, then a short tail for anything stray
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d reply bytes: %0d points and %0d end-of-reply beats checked",
               bytes_sent, points_checked, replies_checked);
      $display("replies ending with 00P %0d, with 10Q %0d, with length error %0d; %0d mismatches",
               replies_ok, replies_retry, replies_bad_len, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_lidar_scan_response_decoder_top OK");
      else
         $display("tb_lidar_scan_response_decoder_top NOT OK");
      $finish;
   end

endmodule
